@@ hw/rtl/spectrum_power_averager_levels_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum power averager.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_POWER_AVERAGER_LEVELS_UNIT_MACROS_SVH
`define SPECTRUM_POWER_AVERAGER_LEVELS_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SPAL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spal: same-cycle check failed");

// Next-cycle implication, off during reset.
`define SPAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spal: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SPAL_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spal: reset check failed");

`endif

@@ hw/rtl/spal_pkg.sv @@
// ----------------------------------------------------------------------------
// spal_pkg
// Types, constants and level tables shared by the spectrum power averager.
// ----------------------------------------------------------------------------
`default_nettype none

package spal_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int PWR_W          = 2 * SAMPLE_BITS;
    localparam int DEF_MAX_BINS   = 1024;
    localparam int DEF_MAX_FRAMES = 1024;
    // wide enough for the largest bin count the parameter range allows
    localparam int TAG_IDX_W      = 13;
    localparam int QUEUE_DEPTH    = 2;

    localparam int BIN_INDEX_W = 10;
    localparam int LEVEL_W     = 4;
    localparam int GLYPH_W     = 7;
    localparam int COLOR_W     = 6;
    localparam int DB_W        = 12;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int BINS_W      = 11;
    localparam int FRAMES_W    = 11;
    localparam int REF_W       = 12;
    localparam int STEP_W      = 10;

    localparam logic [BINS_W-1:0]        RST_BINS   = 11'd256;
    localparam logic [FRAMES_W-1:0]      RST_FRAMES = 11'd64;
    localparam logic signed [REF_W-1:0]  RST_REF    = -12'sd1280;
    localparam logic [STEP_W-1:0]        RST_STEP   = 10'd160;

    localparam logic signed [DB_W-1:0] DB_MIN     = -12'sd2048;
    localparam int                     DB_MAX     = 2047;
    localparam int                     DB_SCALE_W = 22;
    localparam logic [DB_SCALE_W-1:0]  DB_SCALE   = 22'd3156528;
    localparam logic [LEVEL_W-1:0]     LEVEL_MAX  = 4'd9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BINS   = 4'd0,
        REG_FRAMES = 4'd1,
        REG_REF    = 4'd2,
        REG_STEP   = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] bin_real;
        logic signed [SAMPLE_BITS-1:0] bin_imag;
    } t_in_req;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0]   bin_index;
        logic [LEVEL_W-1:0]       level;
        logic [GLYPH_W-1:0]       glyph;
        logic [COLOR_W-1:0]       color_code;
        logic                     row_end;
        logic signed [DB_W-1:0]   max_power_db;
        logic [COLOR_W-1:0]       max_color;
        logic signed [DB_W-1:0]   total_power_db;
        logic [COLOR_W-1:0]       total_color;
    } t_out_req;

    // one classified bin passed from the front to the back
    typedef struct packed {
        logic [PWR_W-1:0]     pwr;
        logic [TAG_IDX_W-1:0] idx;
        logic                 is_first;
        logic                 is_final;
        logic                 is_last;
    } t_task;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lv);
        logic [GLYPH_W-1:0] g;
        case (lv)
            4'd0:    g = 7'd32;  // space
            4'd1:    g = 7'd46;  // .
            4'd2:    g = 7'd58;  // :
            4'd3:    g = 7'd45;  // -
            4'd4:    g = 7'd61;  // =
            4'd5:    g = 7'd43;  // +
            4'd6:    g = 7'd42;  // *
            4'd7:    g = 7'd35;  // #
            4'd8:    g = 7'd37;  // %
            default: g = 7'd64;  // @
        endcase
        return g;
    endfunction

    function automatic logic [COLOR_W-1:0] color_of(input logic [LEVEL_W-1:0] lv);
        logic [COLOR_W-1:0] c;
        case (lv) inside
            [4'd0:4'd3]: c = 6'd34;
            [4'd4:4'd5]: c = 6'd32;
            [4'd6:4'd7]: c = 6'd33;
            default:     c = 6'd31;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spal_ram.sv @@
// ----------------------------------------------------------------------------
// spal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/spal_fifo.sv @@
// ----------------------------------------------------------------------------
// spal_fifo
// Short queue between the classifying front and the processing back.
// ----------------------------------------------------------------------------
`default_nettype none

module spal_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/spal_front.sv @@
// ----------------------------------------------------------------------------
// spal_front
// Accept bins, square them and tag each with its place in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module spal_front
    import spal_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_clear,
    input  wire logic [$clog2(MAX_BINS+1)-1:0]     i_bins,
    input  wire logic [$clog2(MAX_FRAMES+1)-1:0]   i_frames,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire t_in_req                           i_in_req,
    output logic                                   o_push,
    output t_task                                  o_task,
    input  wire logic                              i_full
);

    localparam int BIW = $clog2(MAX_BINS);
    localparam int BCW = $clog2(MAX_BINS + 1);
    localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCW = $clog2(MAX_FRAMES + 1);

    logic [BIW-1:0] r_bin_cnt;
    logic [FIW-1:0] r_frame_cnt;

    logic                   r_s1_valid;
    logic [PWR_W-1:0]       r_sq_re, r_sq_im;
    logic [BIW-1:0]         r_idx;
    logic                   r_first, r_final, r_last;

    logic                   w_accept, w_last, w_final;
    logic signed [PWR_W-1:0] w_sq_re, w_sq_im;

    assign o_in_stall = r_s1_valid && i_full;
    assign o_push     = r_s1_valid && !i_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_last  = (BCW'(r_bin_cnt) + BCW'(1)) >= i_bins;
    assign w_final = (FCW'(r_frame_cnt) + FCW'(1)) >= i_frames;

    assign w_sq_re = i_in_req.bin_real * i_in_req.bin_real;
    assign w_sq_im = i_in_req.bin_imag * i_in_req.bin_imag;

    assign o_task = '{
        pwr:      r_sq_re + r_sq_im,
        idx:      TAG_IDX_W'(r_idx),
        is_first: r_first,
        is_final: r_final,
        is_last:  r_last
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bin_cnt   <= '0;
            r_frame_cnt <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                if (w_last) begin
                    r_bin_cnt   <= '0;
                    r_frame_cnt <= w_final ? '0 : r_frame_cnt + FIW'(1);
                end else begin
                    r_bin_cnt <= r_bin_cnt + BIW'(1);
                end
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sq_re <= $unsigned(w_sq_re);
            r_sq_im <= $unsigned(w_sq_im);
            r_idx   <= r_bin_cnt;
            r_first <= (r_frame_cnt == '0);
            r_final <= w_final;
            r_last  <= w_last;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/spal_back.sv @@
// ----------------------------------------------------------------------------
// spal_back
// Accumulate bin power, average, convert to dB and quantize to levels.
// ----------------------------------------------------------------------------
`default_nettype none

module spal_back
    import spal_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_clear,
    input  wire logic [$clog2(MAX_FRAMES+1)-1:0]   i_frames,
    input  wire logic signed [REF_W-1:0]           i_ref,
    input  wire logic [STEP_W-1:0]                 i_step,
    input  wire logic                              i_empty,
    output logic                                   o_pop,
    input  wire t_task                             i_task,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output t_out_req                               o_out_req
);

    localparam int AW   = $clog2(MAX_BINS);
    localparam int FCW  = $clog2(MAX_FRAMES + 1);
    localparam int SUMW = PWR_W + $clog2(MAX_FRAMES);
    localparam int AVGW = PWR_W;
    localparam int TOTW = PWR_W + $clog2(MAX_BINS);
    localparam int NW   = TOTW;
    localparam int EW   = $clog2(NW);
    localparam int LW   = EW + 16;
    localparam int PRW  = LW + DB_SCALE_W + 1;
    localparam int ITW  = (SUMW > 16) ? SUMW : 16;
    localparam int CNTW = $clog2(ITW + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ADD  = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_NORM = 9'b000001000,
        S_SQR  = 9'b000010000,
        S_DB   = 9'b000100000,
        S_LV0  = 9'b001000000,
        S_LVL  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        P_BIN = 2'd0,
        P_MAX = 2'd1,
        P_TOT = 2'd2
    } t_pass;

    t_state                 r_state, n_state;
    t_pass                  r_pass, n_pass;
    t_task                  r_task, n_task;
    logic [SUMW-1:0]        r_quo, n_quo;
    logic [FCW-1:0]         r_rem, n_rem;
    logic [CNTW-1:0]        r_cnt, n_cnt;
    logic [AVGW-1:0]        r_row_max, n_row_max;
    logic [TOTW-1:0]        r_row_tot, n_row_tot;
    logic [NW-1:0]          r_x, n_x;
    logic [EW-1:0]          r_e, n_e;
    logic [31:0]            r_m, n_m;
    logic [15:0]            r_frac, n_frac;
    logic signed [DB_W-1:0] r_db, n_db;
    logic [DB_W-1:0]        r_lrem, n_lrem;
    logic [LEVEL_W-1:0]     r_lv, n_lv;
    logic [LEVEL_W-1:0]     r_bin_lv, n_bin_lv;
    logic signed [DB_W-1:0] r_max_db, n_max_db, r_tot_db, n_tot_db;
    logic [LEVEL_W-1:0]     r_max_lv, n_max_lv, r_tot_lv, n_tot_lv;
    logic                   r_out_valid, n_out_valid;
    t_out_req               r_out, n_out;

    logic                   w_we;
    logic [SUMW-1:0]        w_rdata, w_sum;
    logic [FCW:0]           w_rem_sh;
    logic                   w_ge;
    logic [AVGW-1:0]        w_avg;
    logic [63:0]            w_sq;
    logic [32:0]            w_sq_sh;
    logic [PRW-1:0]         w_db_prod;
    logic [PRW-33:0]        w_db_q;
    logic signed [DB_W:0]   w_v;

    spal_ram #(
        .WIDTH (SUMW),
        .DEPTH (MAX_BINS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_task.idx[AW-1:0]),
        .i_wdata (w_sum),
        .i_re    (o_pop),
        .i_raddr (i_task.idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // first frame of a row starts from zero; the stored word is stale
    assign w_sum = (r_task.is_first ? '0 : w_rdata) + SUMW'(r_task.pwr);
    assign w_we  = (r_state == S_ADD) && !r_task.is_final;

    assign w_rem_sh = {r_rem, r_quo[SUMW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, i_frames};
    assign w_avg    = AVGW'({r_quo[SUMW-2:0], w_ge});

    assign w_sq      = r_m * r_m;
    assign w_sq_sh   = w_sq[63:31];
    assign w_db_prod = PRW'({r_e, r_frac}) * PRW'(DB_SCALE) + PRW'(64'h8000_0000);
    assign w_db_q    = w_db_prod[PRW-1:32];
    assign w_v       = {r_db[DB_W-1], r_db} - {i_ref[REF_W-1], i_ref};

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_task      = r_task;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_row_max   = r_row_max;
        n_row_tot   = r_row_tot;
        n_x         = r_x;
        n_e         = r_e;
        n_m         = r_m;
        n_frac      = r_frac;
        n_db        = r_db;
        n_lrem      = r_lrem;
        n_lv        = r_lv;
        n_bin_lv    = r_bin_lv;
        n_max_db    = r_max_db;
        n_max_lv    = r_max_lv;
        n_tot_db    = r_tot_db;
        n_tot_lv    = r_tot_lv;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_task  = i_task;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_task.is_final) begin
                    n_quo   = w_sum;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                // one quotient bit a cycle
                n_rem = w_ge ? FCW'(w_rem_sh - {1'b0, i_frames}) : FCW'(w_rem_sh);
                n_quo = {r_quo[SUMW-2:0], w_ge};
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(SUMW - 1)) begin
                    n_row_max = (w_avg > r_row_max) ? w_avg : r_row_max;
                    n_row_tot = r_row_tot + TOTW'(w_avg);
                    n_x       = NW'(w_avg);
                    n_e       = EW'(NW - 1);
                    n_pass    = P_BIN;
                    n_state   = S_NORM;
                end
            end
            S_NORM: begin
                if (r_x == '0) begin
                    n_db    = DB_MIN;
                    n_state = S_LV0;
                end else if (r_x[NW-1]) begin
                    n_m     = r_x[NW-1 -: 32];
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = S_SQR;
                end else begin
                    n_x = {r_x[NW-2:0], 1'b0};
                    n_e = r_e - EW'(1);
                end
            end
            S_SQR: begin
                if (w_sq_sh[32]) begin
                    n_m    = w_sq_sh[32:1];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_m    = w_sq_sh[31:0];
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(15)) begin
                    n_state = S_DB;
                end
            end
            S_DB: begin
                if (w_db_q > (PRW-32)'(DB_MAX)) begin
                    n_db = DB_W'(DB_MAX);
                end else begin
                    n_db = DB_W'(w_db_q);
                end
                n_state = S_LV0;
            end
            S_LV0: begin
                if (i_step == '0) begin
                    n_lv   = LEVEL_MAX;
                    n_lrem = '0;
                end else begin
                    n_lv   = '0;
                    n_lrem = (w_v > 0) ? w_v[DB_W-1:0] : '0;
                end
                n_state = S_LVL;
            end
            S_LVL: begin
                if (r_lv == LEVEL_MAX || r_lrem < DB_W'(i_step)) begin
                    case (r_pass)
                        P_BIN: begin
                            n_bin_lv = r_lv;
                            if (r_task.is_last) begin
                                n_x     = NW'(r_row_max);
                                n_e     = EW'(NW - 1);
                                n_pass  = P_MAX;
                                n_state = S_NORM;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        P_MAX: begin
                            n_max_db = r_db;
                            n_max_lv = r_lv;
                            n_x      = NW'(r_row_tot);
                            n_e      = EW'(NW - 1);
                            n_pass   = P_TOT;
                            n_state  = S_NORM;
                        end
                        default: begin
                            n_tot_db = r_db;
                            n_tot_lv = r_lv;
                            n_state  = S_OUT;
                        end
                    endcase
                end else begin
                    n_lrem = r_lrem - DB_W'(i_step);
                    n_lv   = r_lv + LEVEL_W'(1);
                end
            end
            S_OUT: begin
                // load the output register once it is free
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid          = 1'b1;
                    n_out.bin_index      = BIN_INDEX_W'(r_task.idx);
                    n_out.level          = r_bin_lv;
                    n_out.glyph          = glyph_of(r_bin_lv);
                    n_out.color_code     = color_of(r_bin_lv);
                    n_out.row_end        = r_task.is_last;
                    n_out.max_power_db   = '0;
                    n_out.max_color      = '0;
                    n_out.total_power_db = '0;
                    n_out.total_color    = '0;
                    if (r_task.is_last) begin
                        n_out.max_power_db   = r_max_db;
                        n_out.max_color      = color_of(r_max_lv);
                        n_out.total_power_db = r_tot_db;
                        n_out.total_color    = color_of(r_tot_lv);
                        n_row_max            = '0;
                        n_row_tot            = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_clear) begin
            n_row_max = '0;
            n_row_tot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_max   <= '0;
            r_row_tot   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row_max   <= n_row_max;
            r_row_tot   <= n_row_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass   <= n_pass;
        r_task   <= n_task;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_x      <= n_x;
        r_e      <= n_e;
        r_m      <= n_m;
        r_frac   <= n_frac;
        r_db     <= n_db;
        r_lrem   <= n_lrem;
        r_lv     <= n_lv;
        r_bin_lv <= n_bin_lv;
        r_max_db <= n_max_db;
        r_max_lv <= n_max_lv;
        r_tot_db <= n_tot_db;
        r_tot_lv <= n_tot_lv;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

@@ hw/rtl/spectrum_power_averager_levels_unit.sv @@
// ----------------------------------------------------------------------------
// spectrum_power_averager_levels_unit
// Averaged power spectrum with dB conversion and ten-level display quantizer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload    | request
//  ---------+---------------------------+------------+-------------------------
//  input    | i_in_valid / o_in_stall   | i_in_req   | one FFT bin (re, im)
//  output   | o_out_valid / i_out_stall | o_out_req  | one display level cell
//  config   | i_cfg_we                  | i_cfg_data | register at i_cfg_index
//
//  A bin of a frame that is not the last of a row passes the back as a queue
//  pop with RAM read, then an add and write back. A bin of the final frame
//  also runs the divider, the normalize loop, the squaring log loop, the dB
//  scale and the level search before it is output; the last bin of a row
//  runs the dB and level path twice more. Reset needs no clearing pass: the
//  first frame of each row ignores the stored sums. Output stalls hold the
//  output register; the queue keeps the front accepting until it fills, then
//  o_in_stall rises.
//
`default_nettype none

module spectrum_power_averager_levels_unit
    import spal_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in_req                i_in_req,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_req                    o_out_req
);

    localparam int BCW = $clog2(MAX_BINS + 1);
    localparam int FCW = $clog2(MAX_FRAMES + 1);

    logic [BINS_W-1:0]        r_bins;
    logic [FRAMES_W-1:0]      r_frames;
    logic signed [REF_W-1:0]  r_ref;
    logic [STEP_W-1:0]        r_step;

    logic                     w_clear;
    logic [BCW-1:0]           w_eff_bins;
    logic [FCW-1:0]           w_eff_frames;

    logic                     w_push, w_pop, w_full, w_empty;
    t_task                    w_push_task, w_head_task;

    // a write to either length register restarts the row
    assign w_clear = i_cfg_we &&
                     (t_cfg_reg'(i_cfg_index) == REG_BINS ||
                      t_cfg_reg'(i_cfg_index) == REG_FRAMES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins   <= RST_BINS;
            r_frames <= RST_FRAMES;
            r_ref    <= RST_REF;
            r_step   <= RST_STEP;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BINS:   r_bins   <= i_cfg_data[BINS_W-1:0];
                REG_FRAMES: r_frames <= i_cfg_data[FRAMES_W-1:0];
                REG_REF:    r_ref    <= $signed(i_cfg_data[REF_W-1:0]);
                REG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                default:    ;   // drop writes past the register list
            endcase
        end
    end

    // clamp the lengths into the range the storage supports
    always_comb begin
        if (r_bins == '0) begin
            w_eff_bins = BCW'(1);
        end else if (32'(r_bins) > MAX_BINS) begin
            w_eff_bins = BCW'(MAX_BINS);
        end else begin
            w_eff_bins = BCW'(r_bins);
        end

        if (r_frames == '0) begin
            w_eff_frames = FCW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_eff_frames = FCW'(MAX_FRAMES);
        end else begin
            w_eff_frames = FCW'(r_frames);
        end
    end

    spal_front #(
        .MAX_BINS   (MAX_BINS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_clear),
        .i_bins     (w_eff_bins),
        .i_frames   (w_eff_frames),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_push     (w_push),
        .o_task     (w_push_task),
        .i_full     (w_full)
    );

    spal_fifo #(
        .WIDTH ($bits(t_task)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_task),
        .i_pop   (w_pop),
        .o_data  (w_head_task),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    spal_back #(
        .MAX_BINS   (MAX_BINS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_frames    (w_eff_frames),
        .i_ref       (r_ref),
        .i_step      (r_step),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_task      (w_head_task),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire

@@ hw/rtl/spal_checker.sv @@
// ----------------------------------------------------------------------------
// spal_checker
// Port-level checks on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spectrum_power_averager_levels_unit_macros.svh"

module spal_checker
    import spal_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_req o_out_req
);

    // hold a stalled request
    `SPAL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // row summary fields stay zero off the row end
    `SPAL_ASSERT_SAME(a_summary_zero, i_clk, i_rst_n, o_out_valid && !o_out_req.row_end, o_out_req.max_power_db == 0 && o_out_req.total_power_db == 0 && o_out_req.max_color == 0 && o_out_req.total_color == 0)

    // the row total can never fall below its largest bin
    `SPAL_ASSERT_SAME(a_total_ge_max, i_clk, i_rst_n, o_out_valid && o_out_req.row_end, o_out_req.total_power_db >= o_out_req.max_power_db)

    // reset drops any pending result
    `SPAL_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind spectrum_power_averager_levels_unit spal_checker u_spal_checker (.*);

`default_nettype wire
